[design/rgp_pkg.sv]
// Shared types, constants and arithmetic steps for the radial gradient pixel generator.
`timescale 1ns / 1ps

package rgp_pkg;

  localparam int IMG_WIDTH  = 256;
  localparam int IMG_HEIGHT = 256;

  localparam int PIX_W   = 8;
  localparam int CH_W    = 8;
  localparam int COLOR_W = 32;
  localparam int NUM_CH  = COLOR_W / CH_W;
  localparam int T_FRAC  = 16;
  localparam int T_W     = T_FRAC + 1;

  localparam logic [COLOR_W-1:0] INNER_RESET = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] OUTER_RESET = 32'h3333_33FF;

  typedef enum logic [0:0] {
    REG_INNER = 1'b0,
    REG_OUTER = 1'b1
  } cfg_reg_e;

  localparam int CFG_IDX_W = 1;

  localparam int PIX_MAX = (1 << PIX_W) - 1;
  localparam int CX      = IMG_WIDTH / 2;
  localparam int CY      = IMG_HEIGHT / 2;
  localparam int M_DIM   = (IMG_WIDTH < IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;

  localparam int DX_MAX = (CX > PIX_MAX - CX) ? CX : PIX_MAX - CX;
  localparam int DY_MAX = (CY > PIX_MAX - CY) ? CY : PIX_MAX - CY;
  localparam int DXW    = $clog2(DX_MAX + 1);
  localparam int DYW    = $clog2(DY_MAX + 1);
  localparam int CALC_W = $clog2(((CX > CY) ? CX : CY) + PIX_MAX + 1);
  localparam int D2_MAX = DX_MAX * DX_MAX + DY_MAX * DY_MAX;
  localparam int D2W    = $clog2(D2_MAX + 1);

  // The distance is scaled by 2^(T_FRAC+1) before the root, i.e. 2^(2*T_W) under it.
  localparam int SCALE_SH = 2 * T_W;
  localparam int RAD_W    = ((D2W + SCALE_SH + 3) / 4) * 4;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQ_STG   = ROOT_W / 2;

  // The division by the image dimension is a multiplication by its rounded-up
  // reciprocal, which is exact for every root below M_DIM * 2^T_FRAC.
  localparam int DIV_W  = T_FRAC + $clog2(M_DIM);
  localparam int RCP_SH = DIV_W + $clog2(M_DIM);
  localparam int RCP_W  = DIV_W + 1;
  localparam int QF_W   = DIV_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RCP_SH) + 64'(M_DIM - 1)) / 64'(M_DIM));

  localparam logic [63:0] SAT_LIM = 64'(M_DIM) << T_FRAC;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
  localparam int PROD_W = CH_W + 1 + T_W + 1;
  localparam logic [PROD_W-1:0] T_HALF = PROD_W'(1) << (T_FRAC - 1);

  localparam int S_DIFF  = 0;
  localparam int S_SQR   = 1;
  localparam int S_SUM   = 2;
  localparam int S_ROOT0 = 3;
  localparam int S_CLAMP = S_ROOT0 + SQ_STG;
  localparam int S_DIV   = S_CLAMP + 1;
  localparam int S_MUL   = S_DIV + 1;
  localparam int S_OUT   = S_MUL + 1;
  localparam int NSTG    = S_OUT + 1;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  // One digit of the restoring square root: two radicand bits in, one root bit out.
  function automatic sq_t sq_step(sq_t s);
    sq_t              r;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = s.rad << 2;
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[design/radial_gradient_pixel.sv]
// Radial gradient pixel generator: fully pipelined distance, root, scaling and color blend.
`timescale 1ns / 1ps

// Takes one pixel coordinate per cycle and returns the RGBA color of a radial gradient
// that runs from the inner color at the image center to the outer color at the
// inscribed circle and beyond. The pipeline has 20 register stages at the default
// 256 x 256 image, and the square root unit takes one stage per two root bits. A new
// pixel is accepted every cycle unless the output stalls: the whole pipeline holds
// while a finished pixel waits at the output. The color registers are written through
// the configuration port and are used directly by the blend stages, so they should only
// change while no pixel is in flight.
module radial_gradient_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rgp_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [rgp_pkg::PIX_W-1:0]     pixel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rgp_pkg::CH_W-1:0]      red_o,
  output logic [rgp_pkg::CH_W-1:0]      green_o,
  output logic [rgp_pkg::CH_W-1:0]      blue_o,
  output logic [rgp_pkg::CH_W-1:0]      alpha_o,
  input  logic                          cfg_we_i,
  input  logic [rgp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgp_pkg::COLOR_W-1:0]   cfg_data_i
);
  import rgp_pkg::*;

  logic [COLOR_W-1:0] inner_q;
  logic [COLOR_W-1:0] outer_q;

  logic [NSTG-1:0] v_q;
  logic            adv;

  logic [CALC_W-1:0] dx_d;
  logic [CALC_W-1:0] dy_d;
  logic [DXW-1:0]    dx_q;
  logic [DYW-1:0]    dy_q;
  logic [2*DXW-1:0]  sqx_q;
  logic [2*DYW-1:0]  sqy_q;
  logic [D2W-1:0]    d2_q;
  sq_t               sq_init;
  sq_t               sq_q [SQ_STG];
  logic [DIV_W-1:0]  clamp_d;
  logic              sat_d;
  logic [DIV_W-1:0]  clamp_q;
  logic              sat_q;
  logic [QF_W-1:0]   quo_full;
  logic [T_FRAC-1:0] quo_q;
  logic              dsat_q;
  logic [T_W-1:0]    t_d;
  logic signed [PROD_W-1:0] prod_d [NUM_CH];
  logic signed [PROD_W-1:0] prod_q [NUM_CH];
  logic [CH_W-1:0]          chan_d [NUM_CH];
  logic [CH_W-1:0]          chan_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= INNER_RESET;
      outer_q <= OUTER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_INNER: inner_q <= cfg_data_i;
        REG_OUTER: outer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv        = !v_q[NSTG-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_comb begin
    if (CALC_W'(pixel_x_i) >= CALC_W'(CX)) begin
      dx_d = CALC_W'(pixel_x_i) - CALC_W'(CX);
    end else begin
      dx_d = CALC_W'(CX) - CALC_W'(pixel_x_i);
    end
    if (CALC_W'(pixel_y_i) >= CALC_W'(CY)) begin
      dy_d = CALC_W'(pixel_y_i) - CALC_W'(CY);
    end else begin
      dy_d = CALC_W'(CY) - CALC_W'(pixel_y_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q  <= DXW'(dx_d);
      dy_q  <= DYW'(dy_d);
      sqx_q <= (2*DXW)'(dx_q) * (2*DXW)'(dx_q);
      sqy_q <= (2*DYW)'(dy_q) * (2*DYW)'(dy_q);
      d2_q  <= D2W'(sqx_q) + D2W'(sqy_q);
    end
  end

  always_comb begin
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.rad  = RAD_W'(d2_q) << SCALE_SH;
  end

  for (genvar g = 0; g < SQ_STG; g++) begin : g_root
    sq_t src;
    if (g == 0) begin : g_first
      assign src = sq_init;
    end else begin : g_next
      assign src = sq_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[g] <= sq_step(sq_step(src));
      end
    end
  end

  always_comb begin
    sat_d   = 64'(sq_q[SQ_STG-1].root) >= SAT_LIM;
    clamp_d = DIV_W'(sq_q[SQ_STG-1].root);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clamp_q <= clamp_d;
      sat_q   <= sat_d;
    end
  end

  assign quo_full = QF_W'(clamp_q) * QF_W'(RCP);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      quo_q  <= quo_full[RCP_SH +: T_FRAC];
      dsat_q <= sat_q;
    end
  end

  assign t_d = dsat_q ? T_ONE : T_W'(quo_q);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [CH_W-1:0]          c1;
    logic [CH_W-1:0]          c2;
    logic signed [CH_W:0]     diff;
    logic signed [PROD_W-1:0] sum;
    assign c1   = inner_q[COLOR_W-1-CH_W*c -: CH_W];
    assign c2   = outer_q[COLOR_W-1-CH_W*c -: CH_W];
    assign diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
    assign prod_d[c] = PROD_W'(diff) * $signed(PROD_W'({1'b0, t_d}));
    assign sum = $signed(PROD_W'(c1) << T_FRAC) + prod_q[c] + $signed(T_HALF);
    assign chan_d[c] = sum[T_FRAC +: CH_W];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        prod_q[c] <= prod_d[c];
        chan_q[c] <= chan_d[c];
      end
    end
  end

  assign out_valid_o = v_q[NSTG-1];
  assign red_o       = chan_q[0];
  assign green_o     = chan_q[1];
  assign blue_o      = chan_q[2];
  assign alpha_o     = chan_q[3];

endmodule

[design/rgp_checker.sv]
// Port-level checks for the radial gradient pixel generator and their binding.
`timescale 1ns / 1ps

module rgp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [rgp_pkg::PIX_W-1:0]     pixel_x_i,
  input logic [rgp_pkg::PIX_W-1:0]     pixel_y_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rgp_pkg::CH_W-1:0]      red_o,
  input logic [rgp_pkg::CH_W-1:0]      green_o,
  input logic [rgp_pkg::CH_W-1:0]      blue_o,
  input logic [rgp_pkg::CH_W-1:0]      alpha_o,
  input logic                          cfg_we_i,
  input logic [rgp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [rgp_pkg::COLOR_W-1:0]   cfg_data_i
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // A stalled result transaction keeps its pixel.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(alpha_o))
    else $error("result changed while stalled");

  // With no result waiting, the pipeline must take new pixels.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty output");

  // A result leaving frees a slot, so the input side must not stall.
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while the output drains");

endmodule

bind radial_gradient_pixel rgp_checker u_rgp_checker (.*);
